>>> sv/gota_pkg.sv
// ----------------------------------------------------------------------------
// gota_pkg
// Shared types and constants of the gated object track association unit.
// ----------------------------------------------------------------------------
package gota_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 64;
   localparam int DUMP_LIMIT  = 64;
   localparam int DUMP_N_MAX  = (DUMP_LIMIT < TABLE_DEPTH) ? DUMP_LIMIT : TABLE_DEPTH;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths.
   localparam int REQ_TYPE_W    = 2;
   localparam int OBJ_TYPE_W    = 8;
   localparam int COORD_W       = 32;
   localparam int TAG_W         = 16;
   localparam int ENTRY_IDX_W   = 6;
   localparam int ACTION_W      = 2;
   localparam int MATCH_W       = 7;
   localparam int GATE_W        = 16;
   localparam int GATE_SQ_W     = 2 * GATE_W;
   localparam int DIFF_W        = 16;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_GATE = 1'b0;
   localparam logic [GATE_W-1:0] GATE_RESET = 16'd768;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_FRAME_START = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_OBJECT      = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_FRAME_END   = 2'd2;

   // Entry actions.
   localparam logic [ACTION_W-1:0] ACT_REMAIN  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UPDATED = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADDED   = 2'd2;

   // Result kinds.
   localparam logic KIND_OBJECT = 1'b0;
   localparam logic KIND_DUMP   = 1'b1;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [OBJ_TYPE_W-1:0] object_type;
      logic [COORD_W-1:0]    loc_x;
      logic [COORD_W-1:0]    loc_y;
      logic [TAG_W-1:0]      object_tag;
   } req_data_type;

   typedef struct packed {
      logic                   result_kind;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic                   entry_valid;
      logic [OBJ_TYPE_W-1:0]  out_type;
      logic [COORD_W-1:0]     out_x;
      logic [COORD_W-1:0]     out_y;
      logic [TAG_W-1:0]       out_tag;
      logic [ACTION_W-1:0]    entry_action;
      logic [MATCH_W-1:0]     match_count;
      logic                   table_full;
      logic                   last_record;
   } rsp_data_type;

   // One word of the slot memory.
   typedef struct packed {
      logic [OBJ_TYPE_W-1:0] obj_type;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [TAG_W-1:0]      tag;
      logic                  added;
   } slot_entry_type;

   // Slot read issued toward the distance unit.
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
   } gate_req_type;

   // Verdict of the distance unit for one slot.
   typedef struct packed {
      logic             vld;
      logic             hit;
      logic [IDX_W-1:0] idx;
      logic             busy;
   } gate_res_type;

endpackage

>>> sv/gota_csr.sv
// ----------------------------------------------------------------------------
// gota_csr
// Register port: holds the gate radius and keeps its square ready for the
// distance unit.
// ----------------------------------------------------------------------------
module gota_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gota_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gota_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gota_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [gota_pkg::GATE_SQ_W-1:0]    gate_sq
);
   import gota_pkg::*;

   logic [GATE_W-1:0]    gate_ff;
   logic [GATE_W-1:0]    gate_in;
   logic [GATE_SQ_W-1:0] gate_sq_ff;
   logic [GATE_SQ_W-1:0] gate_sq_in;
   logic                 reg_idx;
   logic                 wr_transfer;

   assign csr_pready  = 1'b1;
   assign reg_idx     = csr_paddr[CSR_ADDR_W-1];
   assign wr_transfer = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      gate_in = gate_ff;
      if (wr_transfer && (reg_idx == REG_GATE)) begin
         gate_in = csr_pwdata[GATE_W-1:0];
      end
      gate_sq_in = {{GATE_W{1'b0}}, gate_ff} * {{GATE_W{1'b0}}, gate_ff};
   end

   always_comb begin
      unique case (reg_idx)
         REG_GATE: csr_prdata = {{(CSR_DATA_W-GATE_W){1'b0}}, gate_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // Square follows radius next cycle; user writes only while idle, unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff    <= GATE_RESET;
         gate_sq_ff <= GATE_SQ_W'(GATE_RESET) * GATE_SQ_W'(GATE_RESET);
      end else begin
         gate_ff    <= gate_in;
         gate_sq_ff <= gate_sq_in;
      end
   end

   assign gate_sq = gate_sq_ff;

endmodule

>>> sv/gota_gate_unit.sv
// ----------------------------------------------------------------------------
// gota_gate_unit
// Shared distance unit: one slot per cycle through absolute difference,
// squaring and the compare against the squared gate.
// ----------------------------------------------------------------------------
module gota_gate_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  gota_pkg::gate_req_type          slot_req,
   input  gota_pkg::slot_entry_type        slot,
   input  logic [gota_pkg::OBJ_TYPE_W-1:0] obj_type,
   input  logic [gota_pkg::COORD_W-1:0]    loc_x,
   input  logic [gota_pkg::COORD_W-1:0]    loc_y,
   input  logic [gota_pkg::GATE_SQ_W-1:0]  gate_sq,
   output gota_pkg::gate_res_type          result
);
   import gota_pkg::*;

   logic [COORD_W-1:0]   dx_full;
   logic [COORD_W-1:0]   dy_full;
   logic                 far;

   logic                 p1_vld_ff;
   logic [IDX_W-1:0]     p1_idx_ff;
   logic                 p1_ok_ff;
   logic                 p1_ok_in;
   logic [DIFF_W-1:0]    p1_dx_ff;
   logic [DIFF_W-1:0]    p1_dy_ff;

   logic                 p2_vld_ff;
   logic [IDX_W-1:0]     p2_idx_ff;
   logic                 p2_ok_ff;
   logic [2*DIFF_W-1:0]  p2_sqx_ff;
   logic [2*DIFF_W-1:0]  p2_sqy_ff;
   logic [2*DIFF_W-1:0]  p2_sqx_in;
   logic [2*DIFF_W-1:0]  p2_sqy_in;
   logic [2*DIFF_W:0]    dist_sq;

   always_comb begin
      dx_full  = (slot.x > loc_x) ? (slot.x - loc_x) : (loc_x - slot.x);
      dy_full  = (slot.y > loc_y) ? (slot.y - loc_y) : (loc_y - slot.y);
      // A difference that does not fit in 16 bits is always outside the gate.
      far      = (|dx_full[COORD_W-1:DIFF_W]) | (|dy_full[COORD_W-1:DIFF_W]);
      p1_ok_in = (slot.obj_type == obj_type) & ~far;
      p2_sqx_in = {{DIFF_W{1'b0}}, p1_dx_ff} * {{DIFF_W{1'b0}}, p1_dx_ff};
      p2_sqy_in = {{DIFF_W{1'b0}}, p1_dy_ff} * {{DIFF_W{1'b0}}, p1_dy_ff};
      dist_sq   = {1'b0, p2_sqx_ff} + {1'b0, p2_sqy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= slot_req.vld;
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= slot_req.idx;
      p1_ok_ff  <= p1_ok_in;
      p1_dx_ff  <= dx_full[DIFF_W-1:0];
      p1_dy_ff  <= dy_full[DIFF_W-1:0];
      p2_idx_ff <= p1_idx_ff;
      p2_ok_ff  <= p1_ok_ff;
      p2_sqx_ff <= p2_sqx_in;
      p2_sqy_ff <= p2_sqy_in;
   end

   always_comb begin
      result.vld  = p2_vld_ff;
      result.hit  = p2_ok_ff & (dist_sq < {1'b0, gate_sq});
      result.idx  = p2_idx_ff;
      result.busy = p1_vld_ff | p2_vld_ff;
   end

endmodule

>>> sv/gated_object_track_association_unit.sv
// ----------------------------------------------------------------------------
// gated_object_track_association_unit
// Track table with gated nearest-neighbor association of map detections.
// ----------------------------------------------------------------------------
// The block handles one request at a time and drops req_ready while it works.
// A frame start is complete once accepted. A detection reads the N visible
// slots out of the slot memory one per cycle into a two-stage distance unit
// behind the memory read register; its result then waits until the previous
// one is taken. A frame end dumps the table one record at a time: each record
// is read into the memory read register and then loaded into the result
// register before the next read begins. An empty table gives its single
// record.
// ----------------------------------------------------------------------------
module gated_object_track_association_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  gota_pkg::req_data_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output gota_pkg::rsp_data_type           rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gota_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gota_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gota_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import gota_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_RESOLVE = 3'd3;
   localparam logic [2:0] ST_DUMP_RD = 3'd4;
   localparam logic [2:0] ST_DUMP_LD = 3'd5;
   localparam logic [2:0] ST_EMPTY   = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       npend_ff, npend_in;
   req_data_type           req_ff, req_in;
   logic [MATCH_W-1:0]     match_ff, match_in;
   logic [IDX_W-1:0]       first_ff, first_in;
   logic [TABLE_DEPTH-1:0] mark_ff, mark_in;
   logic                   p0_vld_ff, p0_vld_in;
   logic [IDX_W-1:0]       p0_idx_ff;
   logic                   rsp_valid_ff;
   logic                   load_rsp;
   rsp_data_type           rsp_data_ff, rsp_data_in;

   slot_entry_type         mem [TABLE_DEPTH];
   slot_entry_type         rdata_ff;
   slot_entry_type         wr_data;
   logic                   rd_en;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [IDX_W-1:0]       scan_idx;

   logic                   accept;
   logic                   out_free;
   logic [CNT_W-1:0]       free_slot;
   logic                   full;
   logic [CNT_W-1:0]       dump_n;
   logic [ACTION_W-1:0]    dump_action;
   logic [GATE_SQ_W-1:0]   gate_sq;
   gate_req_type           gate_req;
   gate_res_type           gate_res;

   gota_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gate_sq     (gate_sq)
   );

   assign gate_req.vld = p0_vld_ff;
   assign gate_req.idx = p0_idx_ff;

   gota_gate_unit u_gate (
      .clock    (clock),
      .reset    (reset),
      .slot_req (gate_req),
      .slot     (rdata_ff),
      .obj_type (req_ff.object_type),
      .loc_x    (req_ff.loc_x),
      .loc_y    (req_ff.loc_y),
      .gate_sq  (gate_sq),
      .result   (gate_res)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign scan_idx  = scan_ff[IDX_W-1:0];
   // Visible slots are 0..count-1; pending ones follow right after them.
   assign free_slot = count_ff + npend_ff;
   assign full      = (free_slot >= CNT_W'(TABLE_DEPTH));
   assign dump_n    = (count_ff < CNT_W'(DUMP_N_MAX)) ? count_ff : CNT_W'(DUMP_N_MAX);
   assign dump_action = mark_ff[scan_idx] ? (rdata_ff.added ? ACT_ADDED : ACT_UPDATED)
                                          : ACT_REMAIN;

   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      count_in    = count_ff;
      npend_in    = npend_ff;
      req_in      = req_ff;
      match_in    = match_ff;
      first_in    = first_ff;
      mark_in     = mark_ff;
      p0_vld_in   = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = gate_res.idx;
      wr_data     = '{obj_type: req_ff.object_type, x: req_ff.loc_x, y: req_ff.loc_y,
                      tag: req_ff.object_tag, added: 1'b0};
      load_rsp    = 1'b0;
      rsp_data_in = rsp_data_ff;

      // A slot inside the gate takes over the detection and is marked updated.
      if (gate_res.vld && gate_res.hit) begin
         wr_en = 1'b1;
         mark_in[gate_res.idx] = 1'b1;
         if (match_ff == '0) begin
            first_in = gate_res.idx;
         end
         if (match_ff != {MATCH_W{1'b1}}) begin
            match_in = match_ff + MATCH_W'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_FRAME_START: begin
                     mark_in = '0;
                  end
                  REQ_OBJECT: begin
                     req_in   = req_data;
                     match_in = '0;
                     scan_in  = '0;
                     state_in = (count_ff == '0) ? ST_RESOLVE : ST_SCAN;
                  end
                  REQ_FRAME_END: begin
                     count_in = free_slot;
                     npend_in = '0;
                     scan_in  = '0;
                     state_in = (free_slot == '0) ? ST_EMPTY : ST_DUMP_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_en     = 1'b1;
            p0_vld_in = 1'b1;
            if (scan_ff == count_ff - CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!p0_vld_ff && !gate_res.busy) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               rsp_data_in.result_kind = KIND_OBJECT;
               rsp_data_in.out_type    = req_ff.object_type;
               rsp_data_in.out_x       = req_ff.loc_x;
               rsp_data_in.out_y       = req_ff.loc_y;
               rsp_data_in.out_tag     = req_ff.object_tag;
               rsp_data_in.match_count = match_ff;
               rsp_data_in.last_record = 1'b1;
               if (match_ff != '0) begin
                  rsp_data_in.entry_index  = ENTRY_IDX_W'(first_ff);
                  rsp_data_in.entry_valid  = 1'b1;
                  rsp_data_in.entry_action = ACT_UPDATED;
                  rsp_data_in.table_full   = 1'b0;
               end else if (full) begin
                  rsp_data_in.entry_index  = '0;
                  rsp_data_in.entry_valid  = 1'b0;
                  rsp_data_in.entry_action = ACT_REMAIN;
                  rsp_data_in.table_full   = 1'b1;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = free_slot[IDX_W-1:0];
                  wr_data.added = 1'b1;
                  mark_in[free_slot[IDX_W-1:0]] = 1'b1;
                  npend_in      = npend_ff + CNT_W'(1);
                  rsp_data_in.entry_index  = ENTRY_IDX_W'(free_slot[IDX_W-1:0]);
                  rsp_data_in.entry_valid  = 1'b1;
                  rsp_data_in.entry_action = ACT_ADDED;
                  rsp_data_in.table_full   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            rd_en    = 1'b1;
            state_in = ST_DUMP_LD;
         end
         ST_DUMP_LD: begin
            if (out_free) begin
               load_rsp = 1'b1;
               rsp_data_in.result_kind  = KIND_DUMP;
               rsp_data_in.entry_index  = ENTRY_IDX_W'(scan_idx);
               rsp_data_in.entry_valid  = 1'b1;
               rsp_data_in.out_type     = rdata_ff.obj_type;
               rsp_data_in.out_x        = rdata_ff.x;
               rsp_data_in.out_y        = rdata_ff.y;
               rsp_data_in.out_tag      = rdata_ff.tag;
               rsp_data_in.entry_action = dump_action;
               rsp_data_in.match_count  = '0;
               rsp_data_in.table_full   = 1'b0;
               rsp_data_in.last_record  = (scan_ff == dump_n - CNT_W'(1));
               if (scan_ff == dump_n - CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  scan_in  = scan_ff + CNT_W'(1);
                  state_in = ST_DUMP_RD;
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_data_in = '0;
               rsp_data_in.result_kind = KIND_DUMP;
               rsp_data_in.last_record = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Slot memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[scan_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         npend_ff     <= '0;
         match_ff     <= '0;
         mark_ff      <= '0;
         p0_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         npend_ff     <= npend_in;
         match_ff     <= match_in;
         mark_ff      <= mark_in;
         p0_vld_ff    <= p0_vld_in;
         rsp_valid_ff <= load_rsp | (rsp_valid_ff & ~rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      first_ff    <= first_in;
      p0_idx_ff   <= scan_idx;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Visible and pending slots together never exceed the table.
   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} + {1'b0, npend_ff}) <= (CNT_W + 1)'(TABLE_DEPTH))
      else $error("visible plus pending slots exceed the table depth");

   // Distance verdicts only come back while a detection is being scanned.
   a_hit_in_scan: assert property (@(posedge clock) disable iff (reset)
      gate_res.vld |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance verdict outside of a scan");

   // Only visible slots are ever matched.
   a_hit_visible: assert property (@(posedge clock) disable iff (reset)
      (gate_res.vld && gate_res.hit) |-> ({1'b0, gate_res.idx} < {1'b0, count_ff}))
      else $error("match reported on a slot that is not visible");

   // A frame end publishes every pending slot.
   a_fend_publish: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == REQ_FRAME_END) |=> (npend_ff == '0))
      else $error("pending slots left after a frame end");

   // A new result is only loaded when the result register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(rsp_data_ff) && rsp_valid_ff))
      else $error("pending result overwritten");

endmodule

>>> tb/gated_object_track_association_unit_tb.sv
// ----------------------------------------------------------------------------
// gated_object_track_association_unit_tb
// Self-checking testbench for the gated object track association unit. A
// behavioral copy of the track table predicts every object answer and every
// dump record. Directed frames cover the gate boundary, class mismatch, the
// pending rule, the empty table and an overflowing table. Random frames follow
// under four idling and stall phases and several gate settings.
// ----------------------------------------------------------------------------
module gated_object_track_association_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gota_pkg::*;

   localparam int DRAIN_CYCLES      = 2 * TABLE_DEPTH + 40;
   localparam int ERROR_PRINT_LIMIT = 40;
   localparam int PHASE_ITEMS       = 12;
   localparam logic [CSR_ADDR_W-1:0] GATE_ADDR = CSR_ADDR_W'(4 * int'(REG_GATE));
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [OBJ_TYPE_W-1:0] TRACK_CLASS = 8'hA5;
   localparam logic [GATE_W-1:0]     GATE_MAX    = 16'hFFFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_data_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Behavioral copy of the track table.
   logic [GATE_W-1:0]     gate_radius = GATE_RESET;
   logic                  trk_valid   [TABLE_DEPTH] = '{default: 1'b0};
   logic                  trk_pending [TABLE_DEPTH] = '{default: 1'b0};
   logic [OBJ_TYPE_W-1:0] trk_type    [TABLE_DEPTH] = '{default: '0};
   logic [COORD_W-1:0]    trk_x       [TABLE_DEPTH] = '{default: '0};
   logic [COORD_W-1:0]    trk_y       [TABLE_DEPTH] = '{default: '0};
   logic [TAG_W-1:0]      trk_tag     [TABLE_DEPTH] = '{default: '0};
   logic [ACTION_W-1:0]   trk_action  [TABLE_DEPTH] = '{default: ACT_REMAIN};
   int unsigned           trk_visible = 0;
   int unsigned           trk_pending_n = 0;

   rsp_data_type          track_records_due[$];
   int                    error_count = 0;
   int                    records_seen = 0;
   int                    req_idle_pct = 0;
   int                    rsp_stall_pct = 0;

   gated_object_track_association_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6ns clock = 1'b1;
      #6ns clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= ERROR_PRINT_LIMIT)
         $display("ERROR at %0t: %s", $realtime, what);
   endtask

   // Squared distance against the squared gate; a spread of 65536 or more on
   // either axis never matches.
   function automatic bit in_gate(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                  logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [63:0]        dist_sq;
      logic [63:0]        gate_sq;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      if (dx >= 32'h0001_0000 || dy >= 32'h0001_0000)
         return 1'b0;
      dist_sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
      gate_sq = 64'(gate_radius) * 64'(gate_radius);
      return dist_sq < gate_sq;
   endfunction

   // Applies one accepted request to the table copy and queues its records.
   function automatic void apply_track_request(req_data_type item);
      rsp_data_type rec;
      int unsigned  hits;
      int unsigned  first_hit;
      int unsigned  free_slot;
      int unsigned  n_dump;
      hits = 0;
      first_hit = 0;
      case (item.req_type)
         REQ_FRAME_START: begin
            for (int k = 0; k < TABLE_DEPTH; k++)
               trk_action[k] = ACT_REMAIN;
         end
         REQ_OBJECT: begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
               if (trk_valid[k] && trk_type[k] == item.object_type &&
                   in_gate(trk_x[k], trk_y[k], item.loc_x, item.loc_y)) begin
                  trk_x[k] = item.loc_x;
                  trk_y[k] = item.loc_y;
                  trk_tag[k] = item.object_tag;
                  trk_action[k] = ACT_UPDATED;
                  if (hits == 0)
                     first_hit = k;
                  hits++;
               end
            end
            rec = '0;
            rec.result_kind = KIND_OBJECT;
            rec.out_type = item.object_type;
            rec.out_x = item.loc_x;
            rec.out_y = item.loc_y;
            rec.out_tag = item.object_tag;
            rec.last_record = 1'b1;
            free_slot = trk_visible + trk_pending_n;
            if (hits > 0) begin
               rec.entry_index = ENTRY_IDX_W'(first_hit);
               rec.entry_valid = 1'b1;
               rec.entry_action = ACT_UPDATED;
               rec.match_count = MATCH_W'((hits > 127) ? 127 : hits);
            end else if (free_slot >= TABLE_DEPTH) begin
               rec.table_full = 1'b1;
            end else begin
               trk_type[free_slot] = item.object_type;
               trk_x[free_slot] = item.loc_x;
               trk_y[free_slot] = item.loc_y;
               trk_tag[free_slot] = item.object_tag;
               trk_action[free_slot] = ACT_ADDED;
               trk_pending[free_slot] = 1'b1;
               trk_pending_n++;
               rec.entry_index = ENTRY_IDX_W'(free_slot);
               rec.entry_valid = 1'b1;
               rec.entry_action = ACT_ADDED;
            end
            track_records_due = {track_records_due, rec};
         end
         REQ_FRAME_END: begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
               if (trk_pending[k]) begin
                  trk_pending[k] = 1'b0;
                  trk_valid[k] = 1'b1;
                  trk_visible++;
               end
            end
            trk_pending_n = 0;
            if (trk_visible == 0) begin
               rec = '0;
               rec.result_kind = KIND_DUMP;
               rec.last_record = 1'b1;
               track_records_due = {track_records_due, rec};
            end else begin
               n_dump = (trk_visible > DUMP_N_MAX) ? DUMP_N_MAX : trk_visible;
               for (int k = 0; k < n_dump; k++) begin
                  rec = '0;
                  rec.result_kind = KIND_DUMP;
                  rec.entry_index = ENTRY_IDX_W'(k);
                  rec.entry_valid = 1'b1;
                  rec.out_type = trk_type[k];
                  rec.out_x = trk_x[k];
                  rec.out_y = trk_y[k];
                  rec.out_tag = trk_tag[k];
                  rec.entry_action = trk_action[k];
                  rec.last_record = (k + 1 == n_dump);
                  track_records_due = {track_records_due, rec};
               end
            end
         end
         default: ;  // the unused code is dropped by the block
      endcase
   endfunction

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("record %0d %s: got %0h, expected %0h",
                                   records_seen, name, got, want));
   endtask

   task automatic check_record(rsp_data_type got);
      rsp_data_type want;
      records_seen++;
      if (track_records_due.size() == 0) begin
         report_mismatch($sformatf("record %0d arrived with nothing due: %h",
                                   records_seen, got));
         return;
      end
      want = track_records_due.pop_front();
      check_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      check_field("entry_index", 64'(got.entry_index), 64'(want.entry_index));
      check_field("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
      check_field("out_type", 64'(got.out_type), 64'(want.out_type));
      check_field("out_x", 64'(got.out_x), 64'(want.out_x));
      check_field("out_y", 64'(got.out_y), 64'(want.out_y));
      check_field("out_tag", 64'(got.out_tag), 64'(want.out_tag));
      check_field("entry_action", 64'(got.entry_action), 64'(want.entry_action));
      check_field("match_count", 64'(got.match_count), 64'(want.match_count));
      check_field("table_full", 64'(got.table_full), 64'(want.table_full));
      check_field("last_record", 64'(got.last_record), 64'(want.last_record));
   endtask

   // Result side: check each transfer, then decide whether to stall next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_record(rsp_data);
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Called at a rising edge. Valid is only lowered when an idle gap follows,
   // so back-to-back items keep it high without a second update in one step.
   task automatic send_item(req_data_type item);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < req_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      apply_track_request(item);
   endtask

   task automatic send_request(logic [REQ_TYPE_W-1:0] code);
      req_data_type item;
      item.req_type = code;
      item.object_type = 8'($urandom);
      item.loc_x = $urandom;
      item.loc_y = $urandom;
      item.object_tag = 16'($urandom);
      send_item(item);
   endtask

   task automatic send_object(logic [OBJ_TYPE_W-1:0] cls, logic [COORD_W-1:0] x,
                              logic [COORD_W-1:0] y, logic [TAG_W-1:0] tag);
      req_data_type item;
      item.req_type = REQ_OBJECT;
      item.object_type = cls;
      item.loc_x = x;
      item.loc_y = y;
      item.object_tag = tag;
      send_item(item);
   endtask

   // Waits until every record has been taken and the block has gone idle.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (track_records_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_transfer(logic write, logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= GATE_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_gate(logic [GATE_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      quiesce();
      csr_transfer(1'b1, CSR_DATA_W'(value), readback);
      gate_radius = value;
      csr_transfer(1'b0, '0, readback);
      if (readback[GATE_W-1:0] !== value)
         report_mismatch($sformatf("gate readback %0h, expected %0h",
                                   readback[GATE_W-1:0], value));
   endtask

   function automatic logic [COORD_W-1:0] jitter(int unsigned span);
      int unsigned m;
      m = $urandom_range(0, span);
      return $urandom_range(0, 1) ? COORD_W'(m) : COORD_W'(-int'(m));
   endfunction

   // Mostly re-detections of visible tracks near the gate edge; the rest are
   // new objects, either anywhere on the map or in a busy cluster.
   task automatic send_random_object();
      logic [OBJ_TYPE_W-1:0] cls;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      int unsigned           k;
      int unsigned           span;
      int unsigned           near_pct;
      near_pct = (trk_visible + trk_pending_n >= 48) ? 95 : 70;
      if (trk_visible > 0 && $urandom_range(0, 99) < near_pct) begin
         k = $urandom_range(0, trk_visible - 1);
         cls = ($urandom_range(0, 9) == 0) ? OBJ_TYPE_W'($urandom_range(0, 3)) : trk_type[k];
         span = gate_radius + gate_radius / 4 + 2;
         x = trk_x[k] + jitter(span);
         y = trk_y[k] + jitter(span);
      end else begin
         cls = ($urandom_range(0, 3) == 0) ? OBJ_TYPE_W'($urandom)
                                           : OBJ_TYPE_W'($urandom_range(0, 3));
         if ($urandom_range(0, 1)) begin
            x = $urandom;
            y = $urandom;
         end else begin
            x = 32'h4000_0000 + $urandom_range(0, 1 << 20);
            y = 32'h2000_0000 + $urandom_range(0, 1 << 20);
         end
      end
      send_object(cls, x, y, TAG_W'($urandom));
   endtask

   task automatic test_empty_table();
      send_request(REQ_FRAME_START);
      send_request(REQ_FRAME_END);
      send_request(REQ_UNUSED);
   endtask

   task automatic test_directed_association();
      send_request(REQ_FRAME_START);
      send_object(8'h00, 32'h0, 32'h0, 16'h0000);
      send_object(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      // Same spot as slot 0, but that slot is still pending: a new slot.
      send_object(8'h00, 32'h0, 32'h0, 16'h1234);
      send_request(REQ_FRAME_END);
      send_request(REQ_FRAME_START);
      send_object(8'h00, 32'd767, 32'h0, 16'h5A5A);
      // Exactly one gate away: not strictly closer, so it is added.
      send_object(8'h00, 32'd1535, 32'h0, 16'hA5A5);
      send_object(8'hFF, 32'hFFFE_FFFF, 32'hFFFF_FFFF, 16'h0F0F);
      send_object(8'h01, 32'h0, 32'h0, 16'hF0F0);
      send_object(8'hFF, 32'hFFFF_FF00, 32'hFFFF_FF00, 16'h00FF);
      send_request(REQ_FRAME_END);
      send_request(REQ_FRAME_START);
      send_request(REQ_FRAME_END);
   endtask

   task automatic test_gate_extremes();
      set_gate('0);
      send_request(REQ_FRAME_START);
      send_object(trk_type[0], trk_x[0], trk_y[0], 16'h1111);
      send_request(REQ_FRAME_END);
      set_gate(GATE_MAX);
      send_request(REQ_FRAME_START);
      send_object(trk_type[0], trk_x[0] + 32'd65534, trk_y[0], 16'h2222);
      send_object(trk_type[0], trk_x[0] + 32'd65536, trk_y[0], 16'h3333);
      send_request(REQ_FRAME_END);
      set_gate(GATE_RESET);
   endtask

   task automatic test_random_traffic();
      int          send_pct [4] = '{0, 48, 0, 22};
      int          stall_pct[4] = '{0, 0, 48, 22};
      logic [GATE_W-1:0] phase_gate[4];
      int          produced;
      int          n_obj;
      phase_gate[0] = GATE_RESET;
      phase_gate[1] = GATE_W'($urandom_range(64, 2047));
      phase_gate[2] = GATE_W'($urandom_range(2048, 65535));
      phase_gate[3] = GATE_W'($urandom_range(1, 400));
      for (int ph = 0; ph < 4; ph++) begin
         set_gate(phase_gate[ph]);
         req_idle_pct = send_pct[ph];
         rsp_stall_pct = stall_pct[ph];
         produced = 0;
         while (produced < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 10) begin
               // Noise: any code with random fields, out of frame order.
               if ($urandom_range(0, 1))
                  send_request(REQ_TYPE_W'($urandom_range(0, 3)));
               else
                  send_random_object();
               produced++;
            end else begin
               send_request(REQ_FRAME_START);
               n_obj = $urandom_range(1, 6);
               repeat (n_obj) send_random_object();
               produced += n_obj + 1;
               // Now and then a frame is left open.
               if ($urandom_range(0, 9) != 0) begin
                  send_request(REQ_FRAME_END);
                  produced++;
               end
            end
         end
      end
      req_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   task automatic test_table_overflow();
      logic [COORD_W-1:0] base_x;
      logic [COORD_W-1:0] base_y;
      base_x = 32'h1234_5678;
      base_y = 32'h0ABC_DEF0;
      req_idle_pct = 22;
      rsp_stall_pct = 22;
      set_gate('0);
      send_request(REQ_FRAME_START);
      while (trk_visible + trk_pending_n < TABLE_DEPTH)
         send_object(TRACK_CLASS, base_x, base_y, TAG_W'($urandom));
      send_object(TRACK_CLASS, base_x, base_y, 16'hDEAD);
      send_object(8'h00, 32'h0, 32'h0, 16'hBEEF);
      send_request(REQ_FRAME_END);
      send_object(TRACK_CLASS, base_x, base_y, 16'hCAFE);
      set_gate(GATE_MAX);
      send_request(REQ_FRAME_START);
      send_object(TRACK_CLASS, base_x + 32'd100, base_y - 32'd100, 16'h7777);
      send_object(TRACK_CLASS, base_x + 32'd65535, base_y, 16'h8888);
      send_request(REQ_FRAME_END);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed_association();
      test_gate_extremes();
      test_random_traffic();
      test_table_overflow();
      quiesce();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
sv/gota_pkg.sv
sv/gota_csr.sv
sv/gota_gate_unit.sv
sv/gated_object_track_association_unit.sv
tb/gated_object_track_association_unit_tb.sv
